// ===== sv/fwdv_pkg.sv =====
// ============================================================================
// fwdv_pkg: shared types and codes for the fixed-weight digit vector generator
// Operation, status and config register codes, the config bundle, popcount.
// ============================================================================
package fwdv_pkg;

    localparam int CFG_W      = 64;
    localparam int CFG_ADDR_W = 3;
    localparam int CNT_W      = 5;
    localparam int MODE_W     = 2;
    localparam int RANK_W     = 4;
    localparam int STATUS_W   = 2;

    typedef logic [CNT_W-1:0]    t_count;
    typedef logic [MODE_W-1:0]   t_mode;
    typedef logic [STATUS_W-1:0] t_status;

    // operations (stream sideband)
    localparam t_mode MODE_ADVANCE  = 2'd0;
    localparam t_mode MODE_REWIND   = 2'd1;
    localparam t_mode MODE_NEIGHBOR = 2'd2;

    // result status
    localparam t_status ST_OK        = 2'd0;
    localparam t_status ST_EXHAUSTED = 2'd1;
    localparam t_status ST_NO_DIGIT  = 2'd2;

    // config register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_NONZERO_COUNT = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_ACTIVE_DIGITS = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_DIGIT_LIMITS  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_START_VECTOR  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_USE_START     = 3'd4;

    typedef struct packed {
        t_count           nz_count;
        t_count           active;
        logic [CFG_W-1:0] limits;
        logic [CFG_W-1:0] start;
        logic             use_start;
    } t_cfg;

    typedef struct packed {
        logic    started;
        t_status status;
    } t_step_ctl;

    function automatic t_count f_popcount(input logic [15:0] v);
        t_count c;
        c = '0;
        for (int i = 0; i < 16; i++) begin
            c = c + t_count'(v[i]);
        end
        return c;
    endfunction

endpackage

// ===== sv/fwdv_scan.sv =====
// ============================================================================
// fwdv_scan: digit scan
// Clamps the active length, masks the vector to it and finds the lowest
// raisable digit and the lowest zero sitting just above a nonzero digit.
// ============================================================================
module fwdv_scan
    import fwdv_pkg::*;
#(
    parameter int N = 16,
    parameter int W = 4
) (
    input  t_count         i_active,
    input  logic [N*W-1:0] i_vec,
    input  logic [N*W-1:0] i_lim,
    output t_count         o_len,
    output logic [N-1:0]   o_en,
    output logic [N-1:0]   o_nz,
    output logic [N*W-1:0] o_cur,
    output logic [N-1:0]   o_raise_oh,
    output logic [N-1:0]   o_zup_oh,
    output logic           o_any_raise,
    output logic           o_any_zup
);

    logic         seen;
    logic         prev_nz;
    logic         raise;
    logic         zup;
    logic [W-1:0] dig;

    always_comb begin
        if (i_active == '0) begin
            o_len = t_count'(1);
        end else if (i_active > t_count'(N)) begin
            o_len = t_count'(N);
        end else begin
            o_len = i_active;
        end
    end

    always_comb begin
        seen        = 1'b0;
        prev_nz     = 1'b0;
        o_any_raise = 1'b0;
        o_any_zup   = 1'b0;
        for (int i = 0; i < N; i++) begin
            o_en[i]          = t_count'(i) < o_len;
            dig              = o_en[i] ? i_vec[i*W +: W] : '0;
            o_cur[i*W +: W]  = dig;
            o_nz[i]          = |dig;
            seen             = seen | o_nz[i];
            raise            = seen && (dig < i_lim[i*W +: W]) && o_en[i];
            o_raise_oh[i]    = raise && !o_any_raise;
            o_any_raise      = o_any_raise | raise;
            zup              = prev_nz && !o_nz[i] && o_en[i];
            o_zup_oh[i]      = zup && !o_any_zup;
            o_any_zup        = o_any_zup | zup;
            prev_nz          = o_nz[i];
        end
    end

endmodule

// ===== sv/fwdv_step.sv =====
// ============================================================================
// fwdv_step: next-state logic
// One operation on the current vector: advance, rewind or neighbor query.
// ============================================================================
module fwdv_step
    import fwdv_pkg::*;
#(
    parameter int N = 16,
    parameter int W = 4
) (
    input  t_mode              i_mode,
    input  logic [RANK_W-1:0]  i_rank,
    input  logic [N*W-1:0]     i_state,
    input  logic               i_started,
    input  t_cfg               i_cfg,
    output logic [N*W-1:0]     o_next_state,
    output logic [N*W-1:0]     o_shown,
    output t_step_ctl          o_ctl
);

    t_count         len;
    logic [N-1:0]   en;
    logic [N-1:0]   nz;
    logic [N*W-1:0] cur;
    logic [N-1:0]   raise_oh;
    logic [N-1:0]   zup_oh;
    logic           any_raise;
    logic           any_zup;

    fwdv_scan #(.N(N), .W(W)) u_scan (
        .i_active    (i_cfg.active),
        .i_vec       (i_state),
        .i_lim       (i_cfg.limits[N*W-1:0]),
        .o_len       (len),
        .o_en        (en),
        .o_nz        (nz),
        .o_cur       (cur),
        .o_raise_oh  (raise_oh),
        .o_zup_oh    (zup_oh),
        .o_any_raise (any_raise),
        .o_any_zup   (any_zup)
    );

    logic [N-1:0]   u_oh;
    logic [W-1:0]   d_u;
    logic [W-1:0]   nv;
    logic           clr;
    logic [N-1:0]   below;
    logic           above;
    logic [N-1:0]   keep;
    t_count         c;
    t_count         k;
    logic [N*W-1:0] adv_vec;
    logic [N*W-1:0] init_vec;
    logic [N*W-1:0] start_vec;
    logic [N*W-1:0] nb_vec;
    logic [N-1:0]   hit;
    logic           found;

    // advance: raise the chosen digit, pack lower nonzero digits down as ones
    always_comb begin
        u_oh = any_raise ? raise_oh : zup_oh;
        d_u  = '0;
        for (int i = 0; i < N; i++) begin
            d_u = d_u | (u_oh[i] ? cur[i*W +: W] : '0);
        end
        nv  = any_raise ? W'(d_u + W'(1)) : W'(1);
        clr = any_raise ? ((d_u == '0) && !u_oh[0]) : 1'b1;
        above = 1'b0;
        for (int i = N - 1; i >= 0; i--) begin
            below[i] = above;
            above    = above | u_oh[i];
        end
        keep = nz & below & ~({N{clr}} & (u_oh >> 1));
        c    = f_popcount(16'(keep));
        for (int i = 0; i < N; i++) begin
            if (below[i]) begin
                adv_vec[i*W +: W] = (t_count'(i) < c) ? W'(1) : '0;
            end else if (u_oh[i]) begin
                adv_vec[i*W +: W] = nv;
            end else begin
                adv_vec[i*W +: W] = cur[i*W +: W];
            end
        end
    end

    // first vector and start vector
    always_comb begin
        k = (i_cfg.nz_count > len) ? len : i_cfg.nz_count;
        for (int i = 0; i < N; i++) begin
            init_vec[i*W +: W]  = (t_count'(i) < k) ? W'(1) : '0;
            start_vec[i*W +: W] = en[i] ? i_cfg.start[i*W +: W] : '0;
        end
    end

    // neighbor: clear the nonzero digit whose rank matches
    always_comb begin
        for (int i = 0; i < N; i++) begin
            hit[i] = nz[i] && (f_popcount(16'(nz) & ((16'd1 << i) - 16'd1))
                               == t_count'(i_rank));
            nb_vec[i*W +: W] = hit[i] ? '0 : cur[i*W +: W];
        end
        found = |hit;
    end

    always_comb begin
        o_next_state   = i_state;
        o_shown        = cur;
        o_ctl.started  = i_started;
        o_ctl.status   = ST_OK;
        case (i_mode)
            MODE_ADVANCE: begin
                if (!i_started) begin
                    o_next_state  = init_vec;
                    o_shown       = init_vec;
                    o_ctl.started = 1'b1;
                end else if (any_raise || any_zup) begin
                    o_next_state = adv_vec;
                    o_shown      = adv_vec;
                end else begin
                    o_ctl.status = ST_EXHAUSTED;
                end
            end
            MODE_REWIND: begin
                if (i_cfg.use_start) begin
                    o_next_state  = start_vec;
                    o_shown       = start_vec;
                    o_ctl.started = 1'b1;
                end else begin
                    o_next_state  = '0;
                    o_shown       = '0;
                    o_ctl.started = 1'b0;
                end
            end
            MODE_NEIGHBOR: begin
                if (found) begin
                    o_shown = nb_vec;
                end else begin
                    o_ctl.status = ST_NO_DIGIT;
                end
            end
            default: begin
                o_ctl.status = ST_OK;
            end
        endcase
    end

endmodule

// ===== sv/fixed_weight_digit_vector_generator.sv =====
// ============================================================================
// fixed_weight_digit_vector_generator: fixed-weight mixed-radix vector source
// Walks every digit vector with a fixed count of nonzero digits under
// per-digit limits; also rewinds and answers neighbor queries.
// ============================================================================
//
// Channel   Dir  Handshake               Payload (lowest bit up)
// --------  ---  ----------------------  ----------------------------------
// s_axis    in   s_axis_tvalid/tready    tuser: mode[1:0]
//                                        tdata: nonzero_rank[3:0], pad[7:4]
// m_axis    out  m_axis_tvalid/tready    tdata: digit_vector[63:0],
//                                        status[65:64], has_more[66], pad
// cfg       in   i_cfg_wr_en             i_cfg_addr, i_cfg_data
//
// Flow: one beat accepted per cycle while results are taken. A beat is
//   registered, then the next-state logic runs on it and writes the vector
//   state and the result register together; that register drives
//   m_axis_tvalid.
// has_more is decoded from the stored vector state and the config, and is
//   steady while the result waits unless the config is written.
// Reset: synchronous, active low; config registers to defaults, block
//   unstarted, both pipeline stages empty.
// Stalls: a held result stops the compute stage; the input stage still takes
//   one more beat, then s_axis_tready drops until the result is taken.
// ============================================================================
module fixed_weight_digit_vector_generator
    import fwdv_pkg::*;
#(
    parameter int MAX_DIGITS = 16,
    parameter int DIGIT_BITS = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // config write port
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_W-1:0]      i_cfg_data,
    // input stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,   // nonzero_rank[3:0]
    input  logic [MODE_W-1:0]     s_axis_tuser,   // mode[1:0]
    // result stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [71:0]           m_axis_tdata    // digit_vector, status, has_more
);

    // digits that fit both the parameter and the 64-bit packed fields
    localparam int LEN_CAP = (MAX_DIGITS < CFG_W / DIGIT_BITS) ?
                             MAX_DIGITS : CFG_W / DIGIT_BITS;
    localparam int VB      = LEN_CAP * DIGIT_BITS;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.nz_count  <= t_count'(1);
            r_cfg.active    <= t_count'(16);
            r_cfg.limits    <= '1;
            r_cfg.start     <= '0;
            r_cfg.use_start <= 1'b0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_addr)
                CFG_NONZERO_COUNT: r_cfg.nz_count  <= i_cfg_data[CNT_W-1:0];
                CFG_ACTIVE_DIGITS: r_cfg.active    <= i_cfg_data[CNT_W-1:0];
                CFG_DIGIT_LIMITS:  r_cfg.limits    <= i_cfg_data;
                CFG_START_VECTOR:  r_cfg.start     <= i_cfg_data;
                CFG_USE_START:     r_cfg.use_start <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // ---- input stage ----
    logic              r_in_valid;
    t_mode             r_in_mode;
    logic [RANK_W-1:0] r_in_rank;
    logic              fire;

    // compute fires when the result register is free or being emptied
    assign fire          = r_in_valid && (!m_axis_tvalid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_mode <= s_axis_tuser;
            r_in_rank <= s_axis_tdata[RANK_W-1:0];
        end
    end

    // ---- vector state and next-state logic ----
    logic [VB-1:0] r_state;
    logic          r_started;
    logic [VB-1:0] n_state;
    logic [VB-1:0] shown;
    t_step_ctl     step_ctl;

    fwdv_step #(.N(LEN_CAP), .W(DIGIT_BITS)) u_step (
        .i_mode       (r_in_mode),
        .i_rank       (r_in_rank),
        .i_state      (r_state),
        .i_started    (r_started),
        .i_cfg        (r_cfg),
        .o_next_state (n_state),
        .o_shown      (shown),
        .o_ctl        (step_ctl)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= '0;
            r_started <= 1'b0;
        end else if (fire) begin
            r_state   <= n_state;
            r_started <= step_ctl.started;
        end
    end

    // ---- result stage ----
    logic            r_out_valid;
    logic [CFG_W-1:0] r_out_vec;
    t_status         r_out_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_vec    <= CFG_W'(shown);
            r_out_status <= step_ctl.status;
        end
    end

    // has_more: state only moves when the result register is free or being
    // emptied, so the stored state is always the one behind the shown result
    logic any_raise;
    logic any_zup;
    logic has_more;

    fwdv_scan #(.N(LEN_CAP), .W(DIGIT_BITS)) u_more_scan (
        .i_active    (r_cfg.active),
        .i_vec       (r_state),
        .i_lim       (r_cfg.limits[VB-1:0]),
        .o_len       (),
        .o_en        (),
        .o_nz        (),
        .o_cur       (),
        .o_raise_oh  (),
        .o_zup_oh    (),
        .o_any_raise (any_raise),
        .o_any_zup   (any_zup)
    );

    assign has_more      = !r_started || any_raise || any_zup;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'b0, has_more, r_out_status, r_out_vec};

endmodule
